// File: design/md5_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 package
// Round constants, shift amounts, message schedule and sequencer states.
// ----------------------------------------------------------------------------
package md5_pkg;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  typedef enum logic [2:0] {
    StIdle,
    StRound,
    StFold,
    StPad,
    StEmit
  } md5_state_e;

  // what happens after the current compression
  typedef enum logic [1:0] {
    NxtAccept,
    NxtPad,
    NxtEmit
  } md5_next_e;

  function automatic logic [31:0] md5_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
      6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
      6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
      6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_s(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'h0: s = 5'd7;  4'h1: s = 5'd12; 4'h2: s = 5'd17; 4'h3: s = 5'd22;
      4'h4: s = 5'd5;  4'h5: s = 5'd9;  4'h6: s = 5'd14; 4'h7: s = 5'd20;
      4'h8: s = 5'd4;  4'h9: s = 5'd11; 4'ha: s = 5'd16; 4'hb: s = 5'd23;
      4'hc: s = 5'd6;  4'hd: s = 5'd10; 4'he: s = 5'd15; 4'hf: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] md5_widx(input logic [5:0] r);
    logic [3:0] w;
    case (r[5:4])
      2'd0: w = r[3:0];
      2'd1: w = 4'(4'd5 * r[3:0] + 4'd1);
      2'd2: w = 4'(4'd3 * r[3:0] + 4'd5);
      2'd3: w = 4'(4'd7 * r[3:0]);
      default: w = 4'd0;
    endcase
    return w;
  endfunction

endpackage

// File: design/md5_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 round unit
// One MD5 round: boolean function, four-way add and left rotate.
// ----------------------------------------------------------------------------
module md5_round import md5_pkg::*; (
  input  logic [5:0]  rnd_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  input  logic [31:0] d_i,
  input  logic [31:0] m_i,
  output logic [31:0] b_o
);
  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] dbl;

  always_comb begin
    case (rnd_i[5:4])
      2'd0: f = (b_i & c_i) | (~b_i & d_i);
      2'd1: f = (b_i & d_i) | (c_i & ~d_i);
      2'd2: f = b_i ^ c_i ^ d_i;
      default: f = c_i ^ (b_i | ~d_i);
    endcase
    sum = a_i + f + md5_k(rnd_i) + m_i;
    dbl = {sum, sum} << md5_s(rnd_i);
    b_o = b_i + dbl[63:32];
  end
endmodule

// File: design/md5_hash_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 hash engine core
// Byte-stream MD5 with a single shared round unit under a sequencer.
// ----------------------------------------------------------------------------
// Input channel: one word per handshake carrying an optional message byte
// (has_byte_i) and an end-of-message flag (last_i). Output channel: four
// digest words, chaining word A first, word_index_o 0..3, last_word_o on D.
// Throughput: a word that neither fills the block nor ends the message
// leaves ready high, so such words can follow back to back. The 64th byte
// of a block starts a compression: the rounds, one round per cycle through
// the round unit, then a fold into the chaining values.
// A last word adds padding at one byte per cycle up to the end of each
// block, one or two compressions, then four output words. The block holds
// ready low from acceptance until its work is done. If the receiver stalls,
// the current digest word is held until taken.
// Reset loads the standard initial chaining values and clears the byte and
// bit counters.
// ----------------------------------------------------------------------------
module md5_hash_engine_core import md5_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        last_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [31:0] digest_word_o,
  output logic [1:0]  word_index_o,
  output logic        last_word_o
);
  md5_state_e  state_q, state_d;
  md5_next_e   nxt_q, nxt_d;
  logic [31:0] ch_q [4];
  logic [31:0] wk_q [4];
  logic [31:0] blk_q [16];
  logic [5:0]  fill_q;
  logic [63:0] len_q, len_snap_q;
  logic [5:0]  rnd_q;
  logic [1:0]  oidx_q;
  logic        pad_first_q;
  logic        two_blk_q;
  logic [31:0] new_b;

  md5_round u_round (
    .rnd_i(rnd_q), .a_i(wk_q[0]), .b_i(wk_q[1]), .c_i(wk_q[2]), .d_i(wk_q[3]),
    .m_i(blk_q[md5_widx(rnd_q)]), .b_o(new_b)
  );

  logic acc;
  assign acc = valid_i && ready_o;

  // pad byte for current fill position; length only in the final block
  logic [7:0] pad_byte;
  always_comb begin
    if (pad_first_q) pad_byte = 8'h80;
    else if (fill_q >= 6'd56 && !two_blk_q) pad_byte = len_snap_q[8*(fill_q[2:0]) +: 8];
    else pad_byte = 8'h00;
  end

  // next state
  always_comb begin
    state_d = state_q;
    nxt_d   = nxt_q;
    case (state_q)
      StIdle: if (acc) begin
        if (has_byte_i && fill_q == 6'd63) begin
          state_d = StRound;
          nxt_d   = last_i ? NxtPad : NxtAccept;
        end else if (last_i) begin
          state_d = StPad;
        end
      end
      StRound: if (rnd_q == 6'd63) state_d = StFold;
      StFold: begin
        case (nxt_q)
          NxtPad:  state_d = StPad;
          NxtEmit: state_d = StEmit;
          default: state_d = StIdle;
        endcase
      end
      StPad: if (fill_q == 6'd63) begin
        state_d = StRound;
        // 0x80 landed in the length area: a second padding block follows
        nxt_d   = (two_blk_q || pad_first_q) ? NxtPad : NxtEmit;
      end
      StEmit: if (ready_i && oidx_q == 2'd3) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // outputs
  always_comb begin
    ready_o       = (state_q == StIdle);
    valid_o       = (state_q == StEmit);
    digest_word_o = ch_q[oidx_q];
    word_index_o  = oidx_q;
    last_word_o   = (oidx_q == 2'd3);
  end

  logic       wr_en;
  logic [7:0] wr_byte;
  always_comb begin
    wr_en   = (acc && has_byte_i) || (state_q == StPad);
    wr_byte = (state_q == StPad) ? pad_byte : data_byte_i;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      if (fill_q[1:0] == 2'd0) blk_q[fill_q[5:2]] <= {24'h0, wr_byte};
      else blk_q[fill_q[5:2]][8*fill_q[1:0] +: 8] <= wr_byte;
    end
    if (acc && last_i) len_snap_q <= has_byte_i ? len_q + 64'd8 : len_q;
    if (state_q == StRound) begin
      wk_q[0] <= wk_q[3];
      wk_q[1] <= new_b;
      wk_q[2] <= wk_q[1];
      wk_q[3] <= wk_q[2];
    end else begin
      for (int i = 0; i < 4; i++) wk_q[i] <= ch_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      nxt_q       <= NxtAccept;
      ch_q[0]     <= InitA;
      ch_q[1]     <= InitB;
      ch_q[2]     <= InitC;
      ch_q[3]     <= InitD;
      fill_q      <= 6'd0;
      len_q       <= 64'd0;
      rnd_q       <= 6'd0;
      oidx_q      <= 2'd0;
      pad_first_q <= 1'b0;
      two_blk_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      nxt_q   <= nxt_d;
      if (wr_en) fill_q <= fill_q + 6'd1;
      if (acc && has_byte_i) len_q <= len_q + 64'd8;
      if (acc) pad_first_q <= last_i;
      else if (state_q == StPad) pad_first_q <= 1'b0;
      if (state_q == StPad && pad_first_q && fill_q >= 6'd56) two_blk_q <= 1'b1;
      else if (state_q == StFold) two_blk_q <= 1'b0;
      if (state_q == StRound) rnd_q <= rnd_q + 6'd1;
      if (state_q == StFold) begin
        for (int i = 0; i < 4; i++) ch_q[i] <= ch_q[i] + wk_q[i];
      end
      if (state_q == StEmit && ready_i) begin
        oidx_q <= oidx_q + 2'd1;
        if (oidx_q == 2'd3) begin
          ch_q[0] <= InitA;
          ch_q[1] <= InitB;
          ch_q[2] <= InitC;
          ch_q[3] <= InitD;
          fill_q  <= 6'd0;
          len_q   <= 64'd0;
        end
      end
    end
  end
endmodule
